@@ rtl/core/md5_pkg.sv @@
// Package with the types, constants and round functions of the MD5 block.
`timescale 1ns / 1ps
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;
  localparam int unsigned QueueDepth = 4;

  // One classified entry between the front and the back.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } md5_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_EMIT
  } md5_state_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

@@ rtl/core/md5_front.sv @@
// Front end: accepts items, drops empty ones and queues the rest for the core.
`timescale 1ns / 1ps
module md5_front
  import md5_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_data_byte,
  input  logic      in_has_byte,
  input  logic      in_end_of_message,
  output logic      q_valid,
  output md5_item_t q_item,
  input  logic      q_take
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  md5_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  // Items with neither a byte nor a last mark do nothing and are dropped.
  assign push = in_valid && !in_stall && (in_has_byte || in_end_of_message);
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_take;
  assign q_item = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? ((wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = pop ? ((rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data: in_data_byte, has_byte: in_has_byte,
                       eom: in_end_of_message};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !push) else $error("push into full queue");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop count slip");
endmodule

@@ rtl/core/md5_core.sv @@
// Back end: block buffer, one-round-per-cycle compression, padding and digest output.
`timescale 1ns / 1ps
module md5_core
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  md5_item_t   q_item,
  output logic        q_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);
  md5_state_t   st_r, st_nxt;
  logic [31:0]  m_r [16];
  logic [31:0]  h_r [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   pos_r, rnd_r;
  logic [63:0]  bits_r;
  logic         fin_r;     // finishing a message: an end-of-message item was taken
  logic         last_r;    // current compression is the length block
  logic         mark_done_r; // the 0x80 mark went into an earlier padding block
  logic [1:0]   oidx_r;

  logic [31:0]  f, g_word, sum, rot, newb;
  logic [4:0]   s;
  logic         len_fits;

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    g_word = m_r[md5_g(rnd_r)];
    sum = a_r + f + md5_k(rnd_r) + g_word;
    s = md5_s(rnd_r);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    newb = b_r + rot;
  end

  // The length fits in this padding block unless the mark lands at byte 56 or later.
  assign len_fits = mark_done_r || (pos_r < LenPos);

  assign q_take = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 2'd3);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.has_byte && pos_r == 6'd63) st_nxt = ST_COMP;
          else if (q_item.eom) st_nxt = ST_PAD;
        end
      end
      ST_COMP: begin
        if (rnd_r == 6'd63) begin
          if (last_r) st_nxt = ST_EMIT;
          else if (fin_r) st_nxt = ST_PAD;
          else st_nxt = ST_IDLE;
        end
      end
      ST_PAD: st_nxt = ST_COMP;
      ST_EMIT: if (!out_stall && oidx_r == 2'd3) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // Byte write into the word-organised buffer, little-endian in each word.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] l,
                                           input logic [7:0] v);
    logic [31:0] r;
    r = w;
    r[l*8 +: 8] = v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= InitA; h_r[1] <= InitB; h_r[2] <= InitC; h_r[3] <= InitD;
      pos_r <= '0; bits_r <= '0; rnd_r <= '0; fin_r <= 1'b0;
      last_r <= 1'b0; mark_done_r <= 1'b0; oidx_r <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.has_byte) begin
              m_r[pos_r[5:2]] <= put_byte(m_r[pos_r[5:2]], pos_r[1:0], q_item.data);
              pos_r <= pos_r + 1'b1;
              bits_r <= bits_r + 64'd8;
            end
            fin_r <= q_item.eom;
            if (q_item.has_byte && pos_r == 6'd63) begin
              a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
              rnd_r <= '0; last_r <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          // Build the padding block in one step: the mark at the byte position
          // (unless an earlier block took it), zeros after it, then the length if it fits.
          for (int w = 0; w < 16; w++) begin
            if (w >= 14 && len_fits) begin
              m_r[w] <= (w == 14) ? bits_r[31:0] : bits_r[63:32];
            end else if (mark_done_r) begin
              m_r[w] <= '0;
            end else begin
              for (int l = 0; l < 4; l++) begin
                if (6'(w*4 + l) == pos_r) m_r[w][l*8 +: 8] <= PadMark;
                else if (6'(w*4 + l) > pos_r) m_r[w][l*8 +: 8] <= 8'h00;
              end
            end
          end
          last_r <= len_fits;
          mark_done_r <= 1'b1;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
          rnd_r <= '0;
        end
        ST_COMP: begin
          a_r <= d_r; b_r <= newb; c_r <= b_r; d_r <= c_r;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            h_r[0] <= h_r[0] + d_r;
            h_r[1] <= h_r[1] + newb;
            h_r[2] <= h_r[2] + b_r;
            h_r[3] <= h_r[3] + c_r;
            if (!fin_r) pos_r <= '0;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 1'b1;
            if (oidx_r == 2'd3) begin
              h_r[0] <= InitA; h_r[1] <= InitB; h_r[2] <= InitC; h_r[3] <= InitD;
              pos_r <= '0; bits_r <= '0; fin_r <= 1'b0; last_r <= 1'b0;
              mark_done_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(last_r) && $past(st_r) == ST_COMP) else $error("emit slip");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !q_take) else $error("take while busy");
  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> oidx_r == 2'd0) else $error("digest not starting at A");
endmodule

@@ rtl/core/md5_message_digest.sv @@
// Top level of the MD5 digest block: front queue and compression core.
`timescale 1ns / 1ps
// Usage: each input item carries one message byte (in_has_byte high) and/or
// an end-of-message mark. An item is taken when in_valid is high and in_stall
// is low. Items with neither byte nor mark are accepted and discarded.
// Accepted items go into a four-entry queue, so the source can keep sending
// while the core compresses. Every 64th byte starts a compression of the
// block, one MD5 round per cycle through a single shared round unit. An
// end-of-message item costs a padding step and a compression, repeated once
// more when the padding spills into an extra block, and then the digest
// leaves as four items, words A to D, out_last_word high on D. Items are
// processed one after another. Each digest word is held while out_stall is
// high; the core waits, and the queue fills and raises in_stall. After D the
// chaining state returns to the MD5 initial values for the next message.
// Synchronous active-low reset empties the queue and restores the initial
// chaining values and counts.
module md5_message_digest
  import md5_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);
  logic      q_valid, q_take;
  md5_item_t q_item;

  md5_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_has_byte,
    .in_end_of_message, .q_valid, .q_item, .q_take
  );

  md5_core u_core (
    .clk, .rst_n, .q_valid, .q_item, .q_take, .out_valid, .out_stall,
    .out_digest_word, .out_word_index, .out_last_word
  );
endmodule

@@ tb/tb_md5_message_digest.sv @@
// Self-checking testbench for the md5_message_digest block.
`timescale 1ns / 1ps
// A driver and a monitor, both clocked always blocks, run against a
// predictor of MD5 written here. The initial block fills a queue of pending
// items and, for each accepted item, the driver works out the digest words
// that the item should cause and appends them to a queue of expected words.
// The monitor compares each accepted digest word with the oldest expected
// word, field by field. The stimulus covers the empty message, messages that
// end on every padding boundary, finalise-only items, noise items that carry
// neither byte nor mark, and a random part that is mostly well-formed
// messages of random length and content.
module tb_md5_message_digest
  import md5_pkg::*;
();

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } msg_item_t;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_word;

  md5_message_digest dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_has_byte(in_has_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  // Round constants and rotation amounts, as MD5 defines them.
  logic [31:0] sine_table [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  int unsigned shift_table [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  // Predictor state: chaining words, block buffer, position and bit count.
  logic [31:0] chain [4];
  logic [7:0]  block_bytes [64];
  logic [5:0]  block_pos;
  logic [63:0] bit_count;

  msg_item_t    pending_items [$];
  digest_word_t expected_words [$];

  int  error_count;
  int  words_seen;
  int  messages_sent;
  longint cycle_count;
  bit  hold_sender;
  bit  long_stall_req;
  bit  no_idle;
  int  stall_cycles;

  // The stall seen at the last rising edge decides whether the item went in.
  logic in_stall_s;

  localparam longint CycleLimit = 400000;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [31:0] spin_left(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One 64-round compression of the block buffer into the chaining words.
  task automatic compress_chain();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    for (int i = 0; i < 16; i++) begin
      m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + spin_left(a + f + sine_table[i] + m[g], shift_table[(i / 16) * 4 + i % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic restart_digest();
    chain[0] = InitA; chain[1] = InitB; chain[2] = InitC; chain[3] = InitD;
    block_pos = '0;
    bit_count = '0;
  endtask

  // Advances the predictor by one accepted item and queues any digest words.
  task automatic predict_digest(input msg_item_t it);
    digest_word_t w;
    int p;
    if (it.has_byte) begin
      block_bytes[block_pos] = it.data;
      block_pos = block_pos + 6'd1;
      bit_count += 64'd8;
      if (block_pos == 6'd0) compress_chain();
    end
    if (it.eom) begin
      p = block_pos;
      block_bytes[p] = PadMark;
      p++;
      if (p > LenPos) begin
        while (p < 64) begin
          block_bytes[p] = 8'h00;
          p++;
        end
        compress_chain();
        p = 0;
      end
      while (p < LenPos) begin
        block_bytes[p] = 8'h00;
        p++;
      end
      for (int k = 0; k < 8; k++) block_bytes[LenPos + k] = bit_count[8*k +: 8];
      compress_chain();
      for (int k = 0; k < 4; k++) begin
        w.word = chain[k];
        w.index = 2'(k);
        w.last = (k == 3);
        expected_words = {expected_words, w};
      end
      restart_digest();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %08h, expected %08h (word %0d)", what, got, want, words_seen);
  endtask

  task automatic queue_item(input logic [7:0] data, input logic has_byte, input logic eom);
    msg_item_t it;
    it.data = data;
    it.has_byte = has_byte;
    it.eom = eom;
    pending_items = {pending_items, it};
  endtask

  // A whole message of len random bytes, the last mark either on the final
  // byte or on a separate finalise-only item.
  task automatic queue_message(input int len);
    bit split_end;
    split_end = (len == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      queue_item(8'($urandom), 1'b1, !split_end && (i == len - 1));
      if ($urandom_range(0, 19) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
    end
    if (split_end) queue_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Driver: offers the head of the pending queue, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_s) begin
        predict_digest(pending_items.pop_front());
      end
      if ((in_valid && in_stall_s) || (pending_items.size() > 0 && !hold_sender &&
          (no_idle || $urandom_range(0, 99) >= 33))) begin
        if (!(in_valid && in_stall_s)) begin
          in_data_byte <= pending_items[0].data;
          in_has_byte <= pending_items[0].has_byte;
          in_end_of_message <= pending_items[0].eom;
        end
        in_valid <= pending_items.size() > 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) in_stall_s <= in_stall;

  // Receiver stall, with a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cycles <= 0;
    end else if (long_stall_req && stall_cycles < 300) begin
      out_stall <= 1'b1;
      stall_cycles <= stall_cycles + 1;
    end else begin
      if (!long_stall_req) stall_cycles <= 0;
      out_stall <= !no_idle && ($urandom_range(0, 99) < 33);
    end
  end

  // Monitor: checks every accepted digest word against the oldest expectation.
  always @(posedge clk) begin
    digest_word_t w;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected digest_word", out_digest_word, 32'h0);
        end else begin
          w = expected_words.pop_front();
          if (out_digest_word !== w.word) report_mismatch("digest_word", out_digest_word, w.word);
          if (out_word_index !== w.index) report_mismatch("word_index", out_word_index, w.index);
          if (out_last_word !== w.last) report_mismatch("last_word", out_last_word, w.last);
        end
      end
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                 expected_words.size());
        $display("tb_md5_message_digest: errors");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
  endtask

  initial begin
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_has_byte = 1'b0;
    in_end_of_message = 1'b0;
    out_stall = 1'b0;
    in_stall_s = 1'b1;
    error_count = 0;
    words_seen = 0;
    messages_sent = 0;
    cycle_count = 0;
    hold_sender = 1'b0;
    long_stall_req = 1'b0;
    no_idle = 1'b0;
    restart_digest();
    for (int i = 0; i < 64; i++) block_bytes[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty message first, then padding boundaries.
    queue_item(8'hff, 1'b0, 1'b1);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'hff, 1'b1, 1'b0);
    queue_item(8'h5a, 1'b0, 1'b1);
    queue_item(8'ha5, 1'b1, 1'b1);
    messages_sent = 4;
    wait_idle();
    // Lengths 55, 56, 63 and 64 straddle the length field and the block end.
    queue_message(55); queue_message(56); queue_message(63);
    queue_message(64);
    messages_sent += 4;

    // Long hold-off on the receiver while the sender keeps offering; the
    // second message backs up behind the held digest and fills the queue.
    no_idle = 1'b1;
    long_stall_req = 1'b1;
    queue_message(20);
    queue_message(30);
    messages_sent += 2;
    wait_idle();
    long_stall_req = 1'b0;
    no_idle = 1'b0;

    // Random part: mostly short messages, a few long ones, some noise.
    while (messages_sent < 22) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 12);
      queue_message(len);
      messages_sent++;
      if (messages_sent == 16) begin
        // Let every pending item and expected word drain first.
        hold_sender = 1'b0;
        wait_idle();
        no_idle = 1'b1;
      end
      if (messages_sent == 19) no_idle = 1'b0;
    end
    wait_idle();
    repeat (300) @(posedge clk);

    $display("covered %0d messages and %0d digest words, including the empty message,",
             messages_sent, words_seen);
    $display("padding boundaries, finalise-only items, noise items and long stalls");
    if (error_count == 0) begin
      $display("tb_md5_message_digest: clean");
    end else begin
      $display("tb_md5_message_digest: errors");
    end
    $finish;
  end

endmodule

@@ md5_message_digest.f @@
rtl/core/md5_pkg.sv
rtl/core/md5_front.sv
rtl/core/md5_core.sv
rtl/core/md5_message_digest.sv
tb/tb_md5_message_digest.sv
